### rtl/core/sms_pkg.sv
// Shared constants, types and helpers for the symbol match scorer.
`default_nettype none

package sms_pkg;

    // Sizes
    localparam int QUERY_MAX_DEF = 32;
    localparam int CHAR_W        = 8;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 64;
    localparam int QLEN_REG_W    = 6;
    localparam int POS_W         = 6;
    localparam int SCORE_W       = 20;
    localparam int KIND_W        = 2;
    localparam int CHARS_REGS    = 4;
    localparam int CHARS_PER_REG = CFG_DATA_W / CHAR_W;

    // Position count saturation value
    localparam logic [POS_W-1:0] POS_SAT = {POS_W{1'b1}};

    // Score constants
    localparam logic [SCORE_W-1:0] SCORE_EXACT  = SCORE_W'(1000000);
    localparam logic [SCORE_W-1:0] SCORE_PREFIX = SCORE_W'(500000);
    localparam logic [SCORE_W-1:0] SCORE_SUBSTR = SCORE_W'(100000);
    localparam logic [SCORE_W-1:0] SCORE_NONE   = '0;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CHARS_0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARS_1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARS_2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARS_3   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_LEN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CASE_SENS = 3'd5;

    // ASCII letter range for case folding
    localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] ASCII_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] ASCII_CASE    = 8'h20;

    // Match kind codes
    typedef enum logic [KIND_W-1:0] {
        KIND_NONE   = 2'd0,
        KIND_SUBSTR = 2'd1,
        KIND_PREFIX = 2'd2,
        KIND_EXACT  = 2'd3
    } kind_t;

    // Fold ASCII upper case to lower unless comparing exactly
    function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c,
                                                    input logic case_sens);
        logic [CHAR_W-1:0] r;
        r = c;
        if (!case_sens && c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z)
            r = c + ASCII_CASE;
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/core/sms_query.sv
// Query configuration registers, folded query bytes and effective length.
`default_nettype none

module sms_query #(
    parameter int QUERY_MAX = sms_pkg::QUERY_MAX_DEF,
    parameter int LEN_W     = $clog2(QUERY_MAX + 1)
) (
    input  wire logic                                          clk,
    input  wire logic                                          rst_n,
    input  wire logic                                          cfg_valid,
    output logic                                               cfg_ready,
    input  wire logic [sms_pkg::CFG_IDX_W-1:0]                 cfg_index,
    input  wire logic [sms_pkg::CFG_DATA_W-1:0]                cfg_data,
    output logic [QUERY_MAX-1:0][sms_pkg::CHAR_W-1:0]          fold_query,
    output logic [LEN_W-1:0]                                   eff_len,
    output logic                                               case_sens
);

    logic [sms_pkg::CHARS_REGS-1:0][sms_pkg::CFG_DATA_W-1:0] chars_reg;
    logic [sms_pkg::QLEN_REG_W-1:0]                          qlen_reg;
    logic                                                    case_reg;
    logic [sms_pkg::CHARS_REGS*sms_pkg::CFG_DATA_W-1:0]      chars_flat;
    logic [LEN_W-1:0]                                        lim;

    // Always ready for a transfer
    assign cfg_ready = 1'b1;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chars_reg <= '0;
            qlen_reg  <= '0;
            case_reg  <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                sms_pkg::CFG_CHARS_0:   chars_reg[0] <= cfg_data;
                sms_pkg::CFG_CHARS_1:   chars_reg[1] <= cfg_data;
                sms_pkg::CFG_CHARS_2:   chars_reg[2] <= cfg_data;
                sms_pkg::CFG_CHARS_3:   chars_reg[3] <= cfg_data;
                sms_pkg::CFG_QUERY_LEN: qlen_reg <= cfg_data[sms_pkg::QLEN_REG_W-1:0];
                sms_pkg::CFG_CASE_SENS: case_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign chars_flat = chars_reg;
    assign case_sens  = case_reg;

    // Fold each query byte once
    always_comb
    begin
        for (int i = 0; i < QUERY_MAX; i++)
            fold_query[i] = sms_pkg::fold_char(chars_flat[i*sms_pkg::CHAR_W +: sms_pkg::CHAR_W],
                                               case_reg);
    end

    // Clamp length, then cut at the first zero byte
    always_comb
    begin
        if (qlen_reg > sms_pkg::QLEN_REG_W'(QUERY_MAX))
            lim = LEN_W'(QUERY_MAX);
        else
            lim = qlen_reg[LEN_W-1:0];
        eff_len = lim;
        for (int i = QUERY_MAX - 1; i >= 0; i--)
        begin
            if (LEN_W'(i) < lim &&
                chars_flat[i*sms_pkg::CHAR_W +: sms_pkg::CHAR_W] == '0)
                eff_len = LEN_W'(i);
        end
    end

endmodule

`default_nettype wire

### rtl/core/symbol_match_scorer_top.sv
// Top level: streamed candidate scoring against the configured query.
// A terminator's score passes the input register, then the result register.
// Throughput: one item per cycle; the input register and the result register
// part the two channels, so a waiting score stalls only a following terminator.
// Reset: rst_n clears the query registers, the match state and both valid flags.
// The effective query length is taken from the registers as they stand.
`default_nettype none

module symbol_match_scorer_top #(
    parameter int QUERY_MAX = sms_pkg::QUERY_MAX_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [sms_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [sms_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [sms_pkg::CHAR_W-1:0]        ch,
    input  wire logic                              end_of_candidate,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [sms_pkg::SCORE_W-1:0]            score,
    output logic [sms_pkg::KIND_W-1:0]             match_kind,
    output logic                                   matched
);

    localparam int LEN_W = $clog2(QUERY_MAX + 1);
    localparam int IDX_W = (QUERY_MAX > 1) ? $clog2(QUERY_MAX) : 1;

    logic [QUERY_MAX-1:0][sms_pkg::CHAR_W-1:0] fold_query;
    logic [LEN_W-1:0]                          eff_len;
    logic                                      case_sens;

    logic                          s1_valid_reg;
    logic [sms_pkg::CHAR_W-1:0]    s1_ch_reg;
    logic                          s1_eoc_reg;

    logic [QUERY_MAX-1:0]          mv_reg, mv_next;
    logic [sms_pkg::POS_W-1:0]     pos_reg, pos_next;
    logic                          prefix_reg, prefix_next;
    logic                          substr_reg, substr_next;

    logic                          out_valid_reg;
    logic [sms_pkg::SCORE_W-1:0]   score_reg, score_next;
    sms_pkg::kind_t                kind_reg, kind_next;

    logic                          out_free;
    logic                          consume;
    logic [sms_pkg::CHAR_W-1:0]    fold_ch;
    logic [QUERY_MAX-1:0]          eq;
    logic [QUERY_MAX-1:0]          mv_step;
    logic [sms_pkg::POS_W-1:0]     pos_step;
    logic [IDX_W-1:0]              last_idx;
    logic                          hit;
    logic [sms_pkg::POS_W-1:0]     len_pos;

    sms_query #(
        .QUERY_MAX (QUERY_MAX),
        .LEN_W     (LEN_W)
    ) u_query (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fold_query (fold_query),
        .eff_len    (eff_len),
        .case_sens  (case_sens)
    );

    // Flow control: only a terminator needs room in the result register
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && s1_eoc_reg && !out_free;
    assign consume  = s1_valid_reg && !in_stall;

    // Hold the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (!in_stall)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            s1_ch_reg  <= ch;
            s1_eoc_reg <= end_of_candidate;
        end
    end

    // Compare the folded byte against every query byte in use
    assign fold_ch  = sms_pkg::fold_char(s1_ch_reg, case_sens);
    assign len_pos  = sms_pkg::POS_W'(eff_len);
    assign last_idx = IDX_W'(eff_len - LEN_W'(1));

    always_comb
    begin
        for (int i = 0; i < QUERY_MAX; i++)
            eq[i] = (LEN_W'(i) < eff_len) && (fold_query[i] == fold_ch);
    end

    assign mv_step  = ((mv_reg << 1) | QUERY_MAX'(1)) & eq;
    assign pos_step = (pos_reg == sms_pkg::POS_SAT) ? pos_reg
                                                    : pos_reg + sms_pkg::POS_W'(1);
    assign hit      = (eff_len != '0) && mv_step[last_idx];

    // Advance the match state, or score and clear on a terminator
    always_comb
    begin
        mv_next     = mv_reg;
        pos_next    = pos_reg;
        prefix_next = prefix_reg;
        substr_next = substr_reg;
        score_next  = sms_pkg::SCORE_NONE;
        kind_next   = sms_pkg::KIND_NONE;

        if (eff_len != '0)
        begin
            if (prefix_reg && pos_reg == len_pos)
            begin
                score_next = sms_pkg::SCORE_EXACT;
                kind_next  = sms_pkg::KIND_EXACT;
            end
            else if (prefix_reg)
            begin
                score_next = sms_pkg::SCORE_PREFIX + sms_pkg::SCORE_W'(eff_len);
                kind_next  = sms_pkg::KIND_PREFIX;
            end
            else if (substr_reg)
            begin
                score_next = sms_pkg::SCORE_SUBSTR + sms_pkg::SCORE_W'(eff_len);
                kind_next  = sms_pkg::KIND_SUBSTR;
            end
        end

        if (consume)
        begin
            if (s1_eoc_reg)
            begin
                mv_next     = '0;
                pos_next    = '0;
                prefix_next = 1'b0;
                substr_next = 1'b0;
            end
            else
            begin
                mv_next  = mv_step;
                pos_next = pos_step;
                if (hit)
                begin
                    substr_next = 1'b1;
                    if (pos_step == len_pos)
                        prefix_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mv_reg     <= '0;
            pos_reg    <= '0;
            prefix_reg <= 1'b0;
            substr_reg <= 1'b0;
        end
        else
        begin
            mv_reg     <= mv_next;
            pos_reg    <= pos_next;
            prefix_reg <= prefix_next;
            substr_reg <= substr_next;
        end
    end

    // Hold the result register until its transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (consume && s1_eoc_reg)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (consume && s1_eoc_reg)
        begin
            score_reg <= score_next;
            kind_reg  <= kind_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign score      = score_reg;
    assign match_kind = kind_reg;
    assign matched    = (kind_reg != sms_pkg::KIND_NONE);

endmodule

`default_nettype wire

### tb/symbol_match_scorer_top_test.sv
// Self-checking testbench for the symbol match scorer: directed and random candidate streams.
module symbol_match_scorer_top_test;
    import sms_pkg::*;

    localparam int HALF_PERIOD   = 2;
    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = 4;
    localparam int RANDOM_ITEMS  = 1350;
    localparam int QUIET_ITEMS   = 200;
    localparam int TIME_LIMIT    = 4000000;

    typedef logic [CHAR_W-1:0] byte_q_t [$];

    typedef struct {
        logic [SCORE_W-1:0] score;
        kind_t              kind;
        logic               matched;
    } score_rec_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [CHAR_W-1:0]     ch = '0;
    logic                  end_of_candidate = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [SCORE_W-1:0]    score;
    logic [KIND_W-1:0]     match_kind;
    logic                  matched;

    // Mirror of the query registers
    logic [CFG_DATA_W-1:0] query_reg [CHARS_REGS] = '{default: '0};
    logic [QLEN_REG_W-1:0] query_len_reg = '0;
    logic                  case_sens_reg = 1'b0;

    // Mirror of the candidate match state
    logic [QUERY_MAX_DEF-1:0] match_bits = '0;
    logic [POS_W-1:0]         chars_seen = '0;
    logic                     prefix_hit = 1'b0;
    logic                     substr_hit = 1'b0;

    score_rec_t pending_scores [$];
    int         mismatch_count = 0;
    int         items_sent = 0;
    bit         gaps_on = 1'b0;
    bit         stalls_on = 1'b0;

    symbol_match_scorer_top u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .ch               (ch),
        .end_of_candidate (end_of_candidate),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .score            (score),
        .match_kind       (match_kind),
        .matched          (matched)
    );

    always #HALF_PERIOD clk = ~clk;

    // Query byte i as held in the register mirror
    function automatic logic [CHAR_W-1:0] query_byte_at(int i);
        return query_reg[i / CHARS_PER_REG][(i % CHARS_PER_REG) * CHAR_W +: CHAR_W];
    endfunction

    // Fold upper case letters unless comparing exactly
    function automatic logic [CHAR_W-1:0] lower_case(logic [CHAR_W-1:0] c);
        if (!case_sens_reg && c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z)
            return c + ASCII_CASE;
        return c;
    endfunction

    // Query length in use: capped at the maximum, cut at the first zero byte
    function automatic int query_span();
        int lim;
        lim = (query_len_reg > QUERY_MAX_DEF) ? QUERY_MAX_DEF : int'(query_len_reg);
        for (int i = 0; i < lim; i++)
            if (query_byte_at(i) == '0)
                return i;
        return lim;
    endfunction

    // Advance the shift-and vector by one candidate byte
    function automatic void track_char(logic [CHAR_W-1:0] c);
        int                       span;
        logic [QUERY_MAX_DEF-1:0] hits;
        logic [CHAR_W-1:0]        fc;
        span = query_span();
        fc   = lower_case(c);
        hits = '0;
        for (int i = 0; i < span; i++)
            if (lower_case(query_byte_at(i)) == fc)
                hits[i] = 1'b1;
        match_bits = ((match_bits << 1) | 1) & hits;
        if (chars_seen != POS_SAT)
            chars_seen++;
        if (span != 0 && match_bits[span-1]) begin
            substr_hit = 1'b1;
            if (chars_seen == span)
                prefix_hit = 1'b1;
        end
    endfunction

    // Rank the finished candidate, queue its score and clear the state
    function automatic void close_candidate();
        int         span;
        score_rec_t rec;
        span = query_span();
        rec.score = SCORE_NONE;
        rec.kind  = KIND_NONE;
        if (span != 0) begin
            if (prefix_hit && chars_seen == span) begin
                rec.score = SCORE_EXACT;
                rec.kind  = KIND_EXACT;
            end else if (prefix_hit) begin
                rec.score = SCORE_PREFIX + SCORE_W'(span);
                rec.kind  = KIND_PREFIX;
            end else if (substr_hit) begin
                rec.score = SCORE_SUBSTR + SCORE_W'(span);
                rec.kind  = KIND_SUBSTR;
            end
        end
        rec.matched = (rec.score != SCORE_NONE);
        pending_scores.push_back(rec);
        match_bits = '0;
        chars_seen = '0;
        prefix_hit = 1'b0;
        substr_hit = 1'b0;
    endfunction

    function automatic void apply_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_CHARS_0, CFG_CHARS_1, CFG_CHARS_2, CFG_CHARS_3: query_reg[idx[1:0]] = data;
            CFG_QUERY_LEN: query_len_reg = data[QLEN_REG_W-1:0];
            CFG_CASE_SENS: case_sens_reg = data[0];
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // Compare one delivered score with the oldest one awaited
    task automatic check_score();
        score_rec_t exp_rec;
        if (pending_scores.size() == 0) begin
            report_mismatch($sformatf("score %0d delivered with none awaited", score));
        end else begin
            exp_rec = pending_scores.pop_front();
            if (score !== exp_rec.score)
                report_mismatch($sformatf("score %0d, want %0d", score, exp_rec.score));
            if (match_kind !== exp_rec.kind)
                report_mismatch($sformatf("match_kind %0d, want %0d", match_kind, exp_rec.kind));
            if (matched !== exp_rec.matched)
                report_mismatch($sformatf("matched %0b, want %0b", matched, exp_rec.matched));
        end
    endtask

    // Watch every channel at the rising edge
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall)
                check_score();
            if (cfg_valid && cfg_ready)
                apply_config(cfg_index, cfg_data);
            if (in_valid && !in_stall) begin
                if (end_of_candidate)
                    close_candidate();
                else
                    track_char(ch);
            end
        end
    end

    // Stall the result channel in bursts, with quiet stretches between
    initial begin
        forever begin
            @(negedge clk);
            if (stalls_on && $urandom_range(0, 5) == 0) begin
                out_stall = 1'b1;
                repeat ($urandom_range(1, 18)) @(negedge clk);
                out_stall = 1'b0;
            end else if ($urandom_range(0, 15) == 0) begin
                repeat ($urandom_range(20, 60)) @(negedge clk);
            end
        end
    end

    // Offer one item and hold it until transfer
    task automatic send_item(logic [CHAR_W-1:0] c, logic term);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        in_valid         = 1'b1;
        ch               = c;
        end_of_candidate = term;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic send_word(byte_q_t w);
        foreach (w[i])
            send_item(w[i], 1'b0);
        send_item(CHAR_W'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], 1'b0);
        send_item(CHAR_W'($urandom_range(0, 255)), 1'b1);
    endtask

    // Drop valid, wait for every awaited score, then let the pipeline empty
    task automatic settle();
        in_valid = 1'b0;
        while (pending_scores.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Write all query registers from a byte image
    task automatic load_query(logic [CHAR_W-1:0] text [QUERY_MAX_DEF],
                              logic [QLEN_REG_W-1:0] len_field, bit sens);
        logic [CFG_DATA_W-1:0] word;
        for (int r = 0; r < CHARS_REGS; r++) begin
            for (int b = 0; b < CHARS_PER_REG; b++)
                word[b * CHAR_W +: CHAR_W] = text[r * CHARS_PER_REG + b];
            write_reg(CFG_IDX_W'(CFG_CHARS_0 + r), word);
        end
        write_reg(CFG_QUERY_LEN, CFG_DATA_W'(len_field));
        write_reg(CFG_CASE_SENS, CFG_DATA_W'(sens));
    endtask

    task automatic load_query_str(string s, logic [QLEN_REG_W-1:0] len_field, bit sens);
        logic [CHAR_W-1:0] text [QUERY_MAX_DEF];
        foreach (text[i])
            text[i] = (i < s.len()) ? s[i] : '0;
        load_query(text, len_field, sens);
    endtask

    // Mostly a few letters in either case, now and then any byte
    function automatic logic [CHAR_W-1:0] rand_letter();
        logic [CHAR_W-1:0] c;
        if ($urandom_range(0, 9) == 0)
            return CHAR_W'($urandom_range(0, 255));
        c = "a" + CHAR_W'($urandom_range(0, 2));
        if ($urandom_range(0, 1) == 1)
            c = c - ASCII_CASE;
        return c;
    endfunction

    // Toggle the case of a letter now and then
    function automatic logic [CHAR_W-1:0] case_flip(logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] low;
        low = c | ASCII_CASE;
        if (low >= "a" && low <= "z" && $urandom_range(0, 3) == 0)
            return c ^ ASCII_CASE;
        return c;
    endfunction

    task automatic test_empty_query();
        send_text("abc");
        send_text("");
        settle();
        load_query_str("abc", '0, 1'b1);
        send_text("abc");
        settle();
        load_query('{default: 8'hFF}, '0, 1'b0);
        send_text("x");
        settle();
    endtask

    task automatic test_match_kinds();
        load_query_str("abc", QLEN_REG_W'(3), 1'b0);
        send_text("abc");
        send_text("ABc");
        send_text("abcd");
        send_text("xabc");
        send_text("xyz");
        send_text("ab");
        settle();
        write_reg(CFG_CASE_SENS, CFG_DATA_W'(1));
        send_text("ABC");
        send_text("abc");
        settle();
    endtask

    task automatic test_query_limits();
        byte_q_t long_word;
        // Zero byte inside the query cuts it to two characters
        load_query_str("ab", QLEN_REG_W'(4), 1'b1);
        send_text("ab");
        // Zero byte in the candidate is an ordinary byte
        send_item("a", 1'b0);
        send_item('0, 1'b0);
        send_text("ab");
        settle();
        // Length field beyond the maximum saturates to the full query
        load_query('{default: "z"}, POS_SAT, 1'b1);
        repeat (QUERY_MAX_DEF) long_word.push_back("z");
        send_word(long_word);
        settle();
    endtask

    task automatic test_config_mid_candidate();
        load_query_str("ab", QLEN_REG_W'(2), 1'b0);
        send_item("a", 1'b0);
        send_item("b", 1'b0);
        settle();
        write_reg(CFG_QUERY_LEN, CFG_DATA_W'(1));
        send_item("a", 1'b0);
        send_item('0, 1'b1);
        settle();
    endtask

    // One random query setting followed by a batch of candidates
    task automatic run_phase(int n_items);
        logic [CHAR_W-1:0]     text [QUERY_MAX_DEF];
        logic [QLEN_REG_W-1:0] len_field;
        byte_q_t               w;
        int                    qlen;
        int                    span;
        int                    stop_at;
        if ($urandom_range(0, 7) == 0) begin
            foreach (text[i])
                text[i] = CHAR_W'($urandom_range(0, 255));
            len_field = QLEN_REG_W'($urandom_range(0, 63));
        end else begin
            case ($urandom_range(0, 5))
                0: qlen = QUERY_MAX_DEF;
                1: qlen = 0;
                default: qlen = $urandom_range(1, 6);
            endcase
            foreach (text[i])
                text[i] = (i < qlen) ? rand_letter() : CHAR_W'($urandom_range(0, 255));
            len_field = QLEN_REG_W'(qlen);
            if ($urandom_range(0, 3) == 0) begin
                if (qlen < QUERY_MAX_DEF)
                    text[qlen] = '0;
                len_field = QLEN_REG_W'($urandom_range(qlen, 63));
            end
        end
        load_query(text, len_field, $urandom_range(0, 1));
        span    = query_span();
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            w = {};
            case ($urandom_range(0, 9))
                0, 1: for (int i = 0; i < span; i++) w.push_back(case_flip(query_byte_at(i)));
                2, 3: begin
                    for (int i = 0; i < span; i++) w.push_back(case_flip(query_byte_at(i)));
                    repeat ($urandom_range(1, 3)) w.push_back(rand_letter());
                end
                4, 5: begin
                    repeat ($urandom_range(1, 3)) w.push_back(rand_letter());
                    for (int i = 0; i < span; i++) w.push_back(case_flip(query_byte_at(i)));
                    repeat ($urandom_range(0, 2)) w.push_back(rand_letter());
                end
                6: begin
                    repeat ($urandom_range(30, 70)) w.push_back(rand_letter());
                    for (int i = 0; i < span; i++) w.push_back(query_byte_at(i));
                end
                default: repeat ($urandom_range(0, 8)) w.push_back(rand_letter());
            endcase
            send_word(w);
        end
        settle();
    endtask

    task automatic test_random_traffic();
        int stop_at;
        stop_at = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at) begin
            gaps_on   = ($urandom_range(0, 3) != 0);
            stalls_on = ($urandom_range(0, 3) != 0);
            run_phase($urandom_range(30, 150));
        end
    endtask

    task automatic test_quiet_traffic();
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        run_phase(QUIET_ITEMS / 2);
        run_phase(QUIET_ITEMS / 2);
    endtask

    initial begin
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        test_empty_query();
        test_match_kinds();
        test_query_limits();
        test_config_mid_candidate();
        test_random_traffic();
        test_quiet_traffic();
        settle();
        if (mismatch_count == 0 && pending_scores.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Give up on a hung run
    initial begin
        #TIME_LIMIT;
        $display("Test completed with failures");
        $finish;
    end

endmodule

### filelist.f
rtl/core/sms_pkg.sv
rtl/core/sms_query.sv
rtl/core/symbol_match_scorer_top.sv
tb/symbol_match_scorer_top_test.sv
